/* rtl/krt_pkg.sv */
// ----------------------------------------------------------------------------
// krt_pkg: shared types and constants for the keyed record table
// Field widths, operation and status codes, the record layout and the
// command and status bundles exchanged by the controller and the datapath.
// ----------------------------------------------------------------------------
package krt_pkg;

   localparam int OP_W       = 2;
   localparam int STAT_W     = 2;
   localparam int KEY_W      = 240;
   localparam int PHONE_W    = 31;
   localparam int REQ_DATA_W = 512;
   localparam int RSP_DATA_W = 32;

   // request tdata layout
   localparam int KEY_LSB    = 0;
   localparam int NEW_LSB    = 240;
   localparam int PHONE_LSB  = 480;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_SEARCH = 2'd1,
      OP_DELETE = 2'd2,
      OP_UPDATE = 2'd3
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_DONE    = 2'd0,
      ST_FULL    = 2'd1,
      ST_MISSING = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      WR_NONE   = 2'd0,
      WR_INSERT = 2'd1,
      WR_UPDATE = 2'd2,
      WR_SHIFT  = 2'd3
   } wr_sel_type;

   // byte 0 of the key sits in the low bits of lo
   typedef struct packed {
      logic [47:0] top;
      logic [63:0] hi;
      logic [63:0] mid;
      logic [63:0] lo;
   } key_type;

   typedef struct packed {
      key_type              key;
      logic [PHONE_W-1:0]   phone;
   } record_type;

   typedef struct packed {
      logic        start;
      logic        scan_read;
      wr_sel_type  wr_sel;
      logic        fill_inc;
      logic        fill_dec;
      logic        set_result;
      status_type  res_status;
      logic        res_from_read;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      op_type  op;
      logic    full;
      logic    scan_end;
      logic    pend;
      logic    match;
   } stat_type;

endpackage

/* rtl/krt_dpath.sv */
// ----------------------------------------------------------------------------
// krt_dpath: keyed record table datapath
// Record memory, fill count, scan pointer with registered read, key compare,
// working result and the output register of the result channel.
// ----------------------------------------------------------------------------
module krt_dpath
   import krt_pkg::*;
#(
   parameter int ENTRIES = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [OP_W-1:0]       req_tuser,
   input  cmd_type               cmd,
   output stat_type              stat,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [STAT_W-1:0]     rsp_tuser
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);

   record_type          mem [ENTRIES];

   op_type              op_ff;
   key_type             key_ff;
   key_type             new_key_ff;
   logic [PHONE_W-1:0]  phone_ff;

   logic [CNT_W-1:0]    fill_ff, fill_in;
   logic [CNT_W-1:0]    scan_ff, scan_in;
   logic                pend_ff, pend_in;
   record_type          rd_data_ff;
   logic [IDX_W-1:0]    rd_idx_ff;

   status_type          res_status_ff;
   logic [PHONE_W-1:0]  res_phone_ff;
   status_type          rsp_status_ff;
   logic [PHONE_W-1:0]  rsp_phone_ff;

   logic                read_issue;
   logic                scan_end;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   record_type          wr_data;

   assign scan_end   = (scan_ff == fill_ff);
   assign read_issue = cmd.scan_read && !scan_end;

   always_comb begin
      wr_en   = 1'b1;
      wr_addr = rd_idx_ff;
      wr_data = rd_data_ff;
      case (cmd.wr_sel)
         WR_INSERT: begin
            wr_addr = fill_ff[IDX_W-1:0];
            wr_data = '{key: key_ff, phone: phone_ff};
         end
         WR_UPDATE: begin
            wr_data = '{key: new_key_ff, phone: phone_ff};
         end
         WR_SHIFT: begin
            // move the entry just read one place down
            wr_addr = rd_idx_ff - IDX_W'(1);
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      fill_in = fill_ff;
      if (cmd.fill_inc) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (cmd.fill_dec) begin
         fill_in = fill_ff - CNT_W'(1);
      end
      if (cmd.start) begin
         scan_in = '0;
      end else if (read_issue) begin
         scan_in = scan_ff + CNT_W'(1);
      end else begin
         scan_in = scan_ff;
      end
      pend_in = read_issue;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         scan_ff <= '0;
         pend_ff <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         scan_ff <= scan_in;
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (read_issue) begin
         rd_data_ff <= mem[scan_ff[IDX_W-1:0]];
         rd_idx_ff  <= scan_ff[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff      <= op_type'(req_tuser);
         key_ff     <= key_type'(req_tdata[KEY_LSB +: KEY_W]);
         new_key_ff <= key_type'(req_tdata[NEW_LSB +: KEY_W]);
         phone_ff   <= req_tdata[PHONE_LSB +: PHONE_W];
      end
      if (cmd.set_result) begin
         res_status_ff <= cmd.res_status;
         res_phone_ff  <= cmd.res_from_read ? rd_data_ff.phone : '0;
      end
      if (cmd.out_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_phone_ff  <= res_phone_ff;
      end
   end

   assign stat.op       = op_ff;
   assign stat.full     = (fill_ff == CNT_W'(ENTRIES));
   assign stat.scan_end = scan_end;
   assign stat.pend     = pend_ff;
   assign stat.match    = pend_ff && (rd_data_ff.key == key_ff);

   assign rsp_tdata = {{(RSP_DATA_W - PHONE_W){1'b0}}, rsp_phone_ff};
   assign rsp_tuser = rsp_status_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(ENTRIES))
      else $error("fill count beyond table depth");

   a_read_valid: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (CNT_W'(rd_idx_ff) < fill_ff))
      else $error("pending read data from an entry past the fill count");

   a_shift_src: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr_sel == WR_SHIFT) |-> (pend_ff && (rd_idx_ff != '0)))
      else $error("compaction write without a fresh source entry");

endmodule

/* rtl/krt_ctrl.sv */
// ----------------------------------------------------------------------------
// krt_ctrl: keyed record table controller
// Sequences insert, scan, compaction and reply, and owns the handshake
// state of both channels.
// ----------------------------------------------------------------------------
module krt_ctrl
   import krt_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_tvalid,
   output logic      req_tready,
   output logic      rsp_tvalid,
   input  logic      rsp_tready,
   input  stat_type  stat,
   output cmd_type   cmd
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_START = 5'b00010,
      S_SCAN  = 5'b00100,
      S_SHIFT = 5'b01000,
      S_REPLY = 5'b10000
   } state_type;

   state_type  state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_free;

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in          = state_ff;
      cmd               = '0;
      cmd.wr_sel        = WR_NONE;
      cmd.res_status    = ST_DONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.start = 1'b1;
               state_in  = S_START;
            end
         end
         S_START: begin
            if (stat.op == OP_INSERT) begin
               cmd.set_result = 1'b1;
               if (stat.full) begin
                  cmd.res_status = ST_FULL;
               end else begin
                  cmd.wr_sel   = WR_INSERT;
                  cmd.fill_inc = 1'b1;
               end
               state_in = S_REPLY;
            end else begin
               cmd.scan_read = 1'b1;
               state_in      = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_read = 1'b1;
            if (stat.match) begin
               case (stat.op)
                  OP_SEARCH: begin
                     cmd.set_result    = 1'b1;
                     cmd.res_from_read = 1'b1;
                     state_in          = S_REPLY;
                  end
                  OP_UPDATE: begin
                     cmd.wr_sel     = WR_UPDATE;
                     cmd.set_result = 1'b1;
                     state_in       = S_REPLY;
                  end
                  default: begin
                     // delete: the read of the next entry is already issued
                     state_in = S_SHIFT;
                  end
               endcase
            end else if (!stat.pend && stat.scan_end) begin
               cmd.set_result = 1'b1;
               cmd.res_status = ST_MISSING;
               state_in       = S_REPLY;
            end
         end
         S_SHIFT: begin
            cmd.scan_read = 1'b1;
            if (stat.pend) begin
               cmd.wr_sel = WR_SHIFT;
            end else if (stat.scan_end) begin
               cmd.fill_dec   = 1'b1;
               cmd.set_result = 1'b1;
               state_in       = S_REPLY;
            end
         end
         S_REPLY: begin
            // hold until the output register can take the result
            if (rsp_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_reply_lands: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_REPLY && rsp_free) |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("finished result not presented on the result channel");

endmodule

/* rtl/keyed_record_table_core.sv */
// ----------------------------------------------------------------------------
// keyed_record_table_core: packed name/phone record table
// Insert, search, delete and update on a table of up to ENTRIES records
// kept in insertion order; delete compacts the table.
//
// channel  dir  tvalid/tready          tdata / tuser
// req      in   req_tvalid/req_tready  key, new key, phone / operation
// rsp      out  rsp_tvalid/rsp_tready  found phone / status
//
// Insert writes the new record at the fill count without a scan. Search,
// update and a miss scan the table: the scan reads one record a cycle
// through the single memory read port. Delete copies each record above the
// hit one place down while the scan runs on.
// Reset clears the fill count and the control state; record contents are
// undefined until written. A stalled result waits in the output register
// while the next request is taken.
// ----------------------------------------------------------------------------
module keyed_record_table_core
   import krt_pkg::*;
#(
   parameter int ENTRIES = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // key_bytes_lo, key_bytes_mid, key_bytes_hi, key_bytes_top,
   // new_bytes_lo, new_bytes_mid, new_bytes_hi, new_bytes_top, phone_value
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // operation
   input  logic [OP_W-1:0]       req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // found_phone
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // status
   output logic [STAT_W-1:0]     rsp_tuser
);

   cmd_type   cmd;
   stat_type  stat;

   krt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   krt_dpath #(
      .ENTRIES (ENTRIES)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

/* sim/keyed_record_table_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_record_table_core testbench
// Drives insert, search, delete and update requests through the request
// stream. A mirror of the record table predicts the status and phone of
// every transfer, and each response is compared against the oldest
// prediction. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
   import krt_pkg::*;

   localparam int TABLE_DEPTH  = 16;
   localparam int STALL_LIMIT  = 2000;
   localparam int BLOCK_ITEMS  = 100;
   localparam int BLOCK_COUNT  = 13;
   localparam int POOL_SIZE    = 12;
   localparam int SETTLE_TIME  = 40;

   typedef struct {
      status_type          status;
      logic [PHONE_W-1:0]  phone;
   } outcome_type;

   // Mirror of the table contents, in insertion order, plus the outcomes
   // still waiting for their response transfer.
   class record_table_mirror;
      key_type             names[$];
      logic [PHONE_W-1:0]  phones[$];
      outcome_type         due_results[$];
      int                  errors;

      function new();
         errors = 0;
      endfunction

      function void note_request(op_type op, key_type key, key_type new_key,
                                 logic [PHONE_W-1:0] phone);
         outcome_type outcome;
         int          hit;
         outcome.status = ST_DONE;
         outcome.phone  = '0;
         hit = -1;
         if (op == OP_INSERT) begin
            if (names.size() >= TABLE_DEPTH) begin
               outcome.status = ST_FULL;
            end else begin
               names.push_back(key);
               phones.push_back(phone);
            end
         end else begin
            // first match wins when names repeat
            for (int i = 0; i < names.size() && hit < 0; i++)
               if (names[i] == key) hit = i;
            if (hit < 0) begin
               outcome.status = ST_MISSING;
            end else begin
               case (op)
                  OP_SEARCH: outcome.phone = phones[hit];
                  OP_DELETE: begin
                     names.delete(hit);
                     phones.delete(hit);
                  end
                  default: begin
                     names[hit]  = new_key;
                     phones[hit] = phone;
                  end
               endcase
            end
         end
         due_results.push_back(outcome);
      endfunction

      function void check_result(logic [STAT_W-1:0] status, logic [PHONE_W-1:0] phone);
         outcome_type outcome;
         if (due_results.size() == 0) begin
            $error("response with nothing pending: status %0d found_phone %0d",
                   status, phone);
            errors++;
            return;
         end
         outcome = due_results.pop_front();
         if (status !== outcome.status) begin
            $error("status mismatch: expected %0d, actual %0d", outcome.status, status);
            errors++;
         end
         if (phone !== outcome.phone) begin
            $error("found_phone mismatch: expected %0d, actual %0d", outcome.phone, phone);
            errors++;
         end
      endfunction

      function int outstanding();
         return due_results.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [OP_W-1:0]       req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STAT_W-1:0]     rsp_tuser;

   record_table_mirror    table_mirror = new();
   key_type               name_pool[POOL_SIZE];
   int                    idle_cycles;

   keyed_record_table_core #(
      .ENTRIES (TABLE_DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic key_type fresh_name();
      logic [KEY_W-1:0] bits;
      int               len;
      bits = '0;
      len  = $urandom_range(0, 1) ? 30 : $urandom_range(1, 29);
      for (int i = 0; i < len; i++) bits[i*8 +: 8] = 8'($urandom);
      return key_type'(bits);
   endfunction

   function automatic key_type pick_target();
      logic [KEY_W-1:0] bits;
      int               r;
      int               n;
      r = $urandom_range(0, 99);
      n = table_mirror.names.size();
      if (n > 0 && r < 60) return table_mirror.names[$urandom_range(0, n - 1)];
      if (n > 0 && r < 70) begin
         // near miss: one bit away from a stored name
         bits = table_mirror.names[$urandom_range(0, n - 1)];
         bits[$urandom_range(0, KEY_W - 1)] ^= 1'b1;
         return key_type'(bits);
      end
      if (r < 88) return name_pool[$urandom_range(0, POOL_SIZE - 1)];
      return fresh_name();
   endfunction

   function automatic key_type pick_new_name();
      int r;
      int n;
      r = $urandom_range(0, 99);
      n = table_mirror.names.size();
      if (r < 50) return name_pool[$urandom_range(0, POOL_SIZE - 1)];
      if (n > 0 && r < 70) return table_mirror.names[$urandom_range(0, n - 1)];
      return fresh_name();
   endfunction

   function automatic logic [PHONE_W-1:0] pick_phone();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5) return '0;
      if (r < 10) return '1;
      return PHONE_W'($urandom);
   endfunction

   // bias 0 fills the table, 1 is even, 2 drains it
   function automatic op_type pick_op(int bias);
      int r;
      int ins_w;
      int del_w;
      r     = $urandom_range(0, 99);
      ins_w = (bias == 0) ? 55 : (bias == 1) ? 25 : 15;
      del_w = (bias == 2) ? 45 : (100 - ins_w) / 3;
      if (r < ins_w) return OP_INSERT;
      if (r < ins_w + del_w) return OP_DELETE;
      if (r < ins_w + del_w + (100 - ins_w - del_w) / 2) return OP_SEARCH;
      return OP_UPDATE;
   endfunction

   // Call at a falling edge; returns at a falling edge after the transfer
   // and the requested gap.
   task automatic put_request(op_type op, key_type key, key_type new_key,
                              logic [PHONE_W-1:0] phone, int gap);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {1'b0, phone, new_key, key};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // response side back-pressure, with calm stretches of no stalls
   initial begin
      int stall_left;
      int calm_left;
      bit calm;
      rsp_tready = 1'b0;
      stall_left = 0;
      calm_left  = 0;
      calm       = 1'b0;
      forever begin
         @(negedge clock);
         if (calm_left == 0) begin
            calm      = ($urandom_range(0, 3) == 0);
            calm_left = $urandom_range(100, 400);
         end
         calm_left--;
         if (stall_left == 0 && !calm) stall_left = pick_gap();
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            table_mirror.check_result(rsp_tuser, rsp_tdata[PHONE_W-1:0]);
         if (req_tvalid && req_tready)
            table_mirror.note_request(op_type'(req_tuser), req_tdata[KEY_LSB +: KEY_W],
                                      req_tdata[NEW_LSB +: KEY_W],
                                      req_tdata[PHONE_LSB +: PHONE_W]);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= STALL_LIMIT) begin
            $display("keyed_record_table_core verification failed");
            $finish;
         end
      end
   end

   initial begin
      key_type ones_key;
      key_type near_key;
      key_type alt_key;
      key_type short_key;
      key_type marked_key;
      op_type  op;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_INSERT;
      reset      = 1'b1;
      ones_key   = '1;
      near_key   = ones_key;
      near_key.top[47:40] = 8'h00;
      alt_key    = fresh_name();
      short_key  = '0;
      short_key.lo[15:0] = 16'h6261;
      // differs only after the zero padding begins
      marked_key = short_key;
      marked_key.top[47:40] = 8'h01;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty table misses, duplicates, first-match rules, compaction
      put_request(OP_SEARCH, '0, '0, '0, pick_gap());
      put_request(OP_DELETE, '0, '0, '0, pick_gap());
      put_request(OP_UPDATE, '0, ones_key, '1, pick_gap());
      put_request(OP_INSERT, '0, '0, '0, pick_gap());
      put_request(OP_INSERT, ones_key, '0, '1, pick_gap());
      put_request(OP_INSERT, ones_key, '0, 31'd1, pick_gap());
      put_request(OP_SEARCH, ones_key, '0, '0, pick_gap());
      put_request(OP_SEARCH, near_key, '0, '0, pick_gap());
      put_request(OP_UPDATE, ones_key, alt_key, 31'd5, pick_gap());
      put_request(OP_SEARCH, ones_key, '0, '0, pick_gap());
      put_request(OP_SEARCH, alt_key, '0, '0, pick_gap());
      put_request(OP_DELETE, '0, '0, '0, pick_gap());
      put_request(OP_SEARCH, ones_key, '0, '0, pick_gap());
      put_request(OP_DELETE, ones_key, '0, '0, pick_gap());
      put_request(OP_DELETE, alt_key, '0, '0, pick_gap());
      put_request(OP_SEARCH, alt_key, '0, '0, pick_gap());
      put_request(OP_INSERT, short_key, '0, 31'h2AAA_5555, pick_gap());
      put_request(OP_SEARCH, marked_key, '0, '0, pick_gap());
      put_request(OP_SEARCH, short_key, '0, '0, pick_gap());
      put_request(OP_UPDATE, short_key, '1, 31'h5555_2AAA, pick_gap());
      put_request(OP_SEARCH, '1, '0, '0, pick_gap());

      for (int b = 0; b < BLOCK_COUNT; b++) begin
         foreach (name_pool[i]) name_pool[i] = fresh_name();
         for (int j = 0; j < BLOCK_ITEMS; j++) begin
            op = pick_op(b % 3);
            put_request(op, (op == OP_INSERT) ? name_pool[$urandom_range(0, POOL_SIZE - 1)]
                                              : pick_target(),
                        pick_new_name(), pick_phone(), (b % 4 == 3) ? 0 : pick_gap());
         end
      end
      req_tvalid <= 1'b0;

      while (table_mirror.outstanding() > 0) @(posedge clock);
      repeat (SETTLE_TIME) @(posedge clock);
      if (table_mirror.errors == 0 && table_mirror.outstanding() == 0) begin
         $display("keyed_record_table_core verification clean");
      end else begin
         $display("keyed_record_table_core verification failed");
      end
      $finish;
   end

endmodule
